/* design/slh_pkg.sv */
`default_nettype none
package slh_pkg;

   localparam int LOOKAHEAD_DEPTH = 16;
   localparam int CNT_W = $clog2(LOOKAHEAD_DEPTH + 1);
   localparam int IDX_W = $clog2(LOOKAHEAD_DEPTH);
   localparam int NUM_KW = 54;
   localparam int KW_IDX_W = 6;
   localparam int KW_MAX = 14;

   // Style codes.
   localparam logic [3:0] STY_PLAIN    = 4'd0;
   localparam logic [3:0] STY_COMMENT  = 4'd1;
   localparam logic [3:0] STY_LONGCMT  = 4'd2;
   localparam logic [3:0] STY_FUNCTION = 4'd3;
   localparam logic [3:0] STY_KEYWORD  = 4'd4;
   localparam logic [3:0] STY_NUMBER   = 4'd5;
   localparam logic [3:0] STY_SSTRING  = 4'd6;
   localparam logic [3:0] STY_DSTRING  = 4'd7;
   localparam logic [3:0] STY_BRACE    = 4'd8;

   // Contexts.
   localparam logic [1:0] CTX_PLAIN   = 2'd0;
   localparam logic [1:0] CTX_DSTRING = 2'd1;
   localparam logic [1:0] CTX_SSTRING = 2'd2;
   localparam logic [1:0] CTX_LONGCMT = 2'd3;

   // Lexer modes.
   localparam logic [1:0] MODE_NONE    = 2'd0;
   localparam logic [1:0] MODE_NUMBER  = 2'd1;
   localparam logic [1:0] MODE_WORD    = 2'd2;
   localparam logic [1:0] MODE_LINECMT = 2'd3;

   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DASH   = 8'h2d;
   localparam logic [7:0] CH_LBRACK = 8'h5b;
   localparam logic [7:0] CH_RBRACK = 8'h5d;
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_UNDER  = 8'h5f;

   typedef enum logic [1:0] {KW_SKIP, KW_WAIT, KW_MATCH} kw_verdict_type;

   typedef struct packed {
      logic [3:0] sty;
      logic [3:0] len;
      logic [KW_MAX-1:0][7:0] txt;
   } kw_entry_type;

   typedef struct packed {
      kw_verdict_type verdict;
      logic [3:0] sty;
      logic [3:0] len;
   } kw_result_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
      logic [7:0] data;
   } la_ctrl_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
   endfunction

   function automatic logic is_numch(input logic [7:0] c);
      return is_digit(c) || (c == CH_DOT) || (c == 8'h65) || (c == 8'h45);
   endfunction

   // The text literal arrives right-justified; the entry holds character j in txt[j].
   function automatic kw_entry_type make_kw(input logic [3:0] sty, input int l,
                                            input logic [8*KW_MAX-1:0] raw);
      kw_entry_type e;
      e.sty = sty;
      e.len = 4'(l);
      e.txt = '0;
      for (int j = 0; j < KW_MAX; j++) begin
         if (j < l) begin
            e.txt[j] = raw[8*(l-1-j) +: 8];
         end
      end
      return e;
   endfunction

   function automatic kw_entry_type kw_rom(input logic [KW_IDX_W-1:0] idx);
      kw_entry_type e;
      case (idx)
         6'd0:  e = make_kw(STY_NUMBER, 3, "nil");
         6'd1:  e = make_kw(STY_NUMBER, 4, "true");
         6'd2:  e = make_kw(STY_NUMBER, 5, "false");
         6'd3:  e = make_kw(STY_NUMBER, 2, "_G");
         6'd4:  e = make_kw(STY_NUMBER, 8, "_VERSION");
         6'd5:  e = make_kw(STY_KEYWORD, 3, "and");
         6'd6:  e = make_kw(STY_KEYWORD, 5, "break");
         6'd7:  e = make_kw(STY_KEYWORD, 2, "do");
         6'd8:  e = make_kw(STY_KEYWORD, 4, "else");
         6'd9:  e = make_kw(STY_KEYWORD, 6, "elseif");
         6'd10: e = make_kw(STY_KEYWORD, 3, "end");
         6'd11: e = make_kw(STY_KEYWORD, 3, "for");
         6'd12: e = make_kw(STY_KEYWORD, 8, "function");
         6'd13: e = make_kw(STY_KEYWORD, 2, "if");
         6'd14: e = make_kw(STY_KEYWORD, 2, "in");
         6'd15: e = make_kw(STY_KEYWORD, 5, "local");
         6'd16: e = make_kw(STY_KEYWORD, 3, "nil");
         6'd17: e = make_kw(STY_KEYWORD, 3, "not");
         6'd18: e = make_kw(STY_KEYWORD, 2, "or");
         6'd19: e = make_kw(STY_KEYWORD, 6, "repeat");
         6'd20: e = make_kw(STY_KEYWORD, 6, "return");
         6'd21: e = make_kw(STY_KEYWORD, 4, "then");
         6'd22: e = make_kw(STY_KEYWORD, 5, "until");
         6'd23: e = make_kw(STY_KEYWORD, 5, "while");
         6'd24: e = make_kw(STY_FUNCTION, 4, "next");
         6'd25: e = make_kw(STY_FUNCTION, 5, "pairs");
         6'd26: e = make_kw(STY_FUNCTION, 6, "ipairs");
         6'd27: e = make_kw(STY_FUNCTION, 6, "assert");
         6'd28: e = make_kw(STY_FUNCTION, 14, "collectgarbage");
         6'd29: e = make_kw(STY_FUNCTION, 6, "dofile");
         6'd30: e = make_kw(STY_FUNCTION, 5, "error");
         6'd31: e = make_kw(STY_FUNCTION, 7, "getfenv");
         6'd32: e = make_kw(STY_FUNCTION, 12, "getmetatable");
         6'd33: e = make_kw(STY_FUNCTION, 7, "setfenv");
         6'd34: e = make_kw(STY_FUNCTION, 12, "setmetatable");
         6'd35: e = make_kw(STY_FUNCTION, 4, "load");
         6'd36: e = make_kw(STY_FUNCTION, 8, "loadfile");
         6'd37: e = make_kw(STY_FUNCTION, 10, "loadstring");
         6'd38: e = make_kw(STY_FUNCTION, 5, "pcall");
         6'd39: e = make_kw(STY_FUNCTION, 5, "print");
         6'd40: e = make_kw(STY_FUNCTION, 8, "rawequal");
         6'd41: e = make_kw(STY_FUNCTION, 6, "rawget");
         6'd42: e = make_kw(STY_FUNCTION, 6, "rawset");
         6'd43: e = make_kw(STY_FUNCTION, 6, "select");
         6'd44: e = make_kw(STY_FUNCTION, 8, "tonumber");
         6'd45: e = make_kw(STY_FUNCTION, 8, "tostring");
         6'd46: e = make_kw(STY_FUNCTION, 4, "type");
         6'd47: e = make_kw(STY_FUNCTION, 6, "unpack");
         6'd48: e = make_kw(STY_FUNCTION, 6, "xpcall");
         6'd49: e = make_kw(STY_FUNCTION, 12, "table.insert");
         6'd50: e = make_kw(STY_FUNCTION, 12, "table.remove");
         6'd51: e = make_kw(STY_FUNCTION, 10, "con.printf");
         6'd52: e = make_kw(STY_FUNCTION, 10, "con.ticker");
         6'd53: e = make_kw(STY_FUNCTION, 9, "con.abort");
         default: e = make_kw(STY_PLAIN, KW_MAX, '0);
      endcase
      return e;
   endfunction

endpackage
`default_nettype wire

/* design/slh_lookahead.sv */
`default_nettype none
module slh_lookahead (
   input  wire logic clock,
   input  wire logic reset,
   input  wire slh_pkg::la_ctrl_type ctrl,
   output logic [slh_pkg::LOOKAHEAD_DEPTH-1:0][7:0] buf_out,
   output logic [slh_pkg::CNT_W-1:0] cnt_out
);

   logic [slh_pkg::LOOKAHEAD_DEPTH-1:0][7:0] buf_ff, buf_in;
   logic [slh_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [slh_pkg::CNT_W-1:0] base;

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      base = ctrl.clear ? '0 : cnt_ff;
      if (ctrl.pop) begin
         // The front character leaves; everything behind it moves up one place.
         for (int i = 0; i < slh_pkg::LOOKAHEAD_DEPTH - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         cnt_in = cnt_ff - slh_pkg::CNT_W'(1);
      end else if (ctrl.push) begin
         cnt_in = base;
         if (base < slh_pkg::CNT_W'(slh_pkg::LOOKAHEAD_DEPTH)) begin
            buf_in[base[slh_pkg::IDX_W-1:0]] = ctrl.data;
            cnt_in = base + slh_pkg::CNT_W'(1);
         end
      end else if (ctrl.clear) begin
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      buf_ff <= buf_in;
   end

   assign buf_out = buf_ff;
   assign cnt_out = cnt_ff;

endmodule
`default_nettype wire

/* design/slh_kw_unit.sv */
`default_nettype none
module slh_kw_unit (
   input  wire logic [slh_pkg::KW_IDX_W-1:0] idx,
   input  wire logic [slh_pkg::LOOKAHEAD_DEPTH-1:0][7:0] la_buf,
   input  wire logic [slh_pkg::CNT_W-1:0] la_cnt,
   input  wire logic fin,
   output slh_pkg::kw_result_type result
);

   slh_pkg::kw_entry_type entry;
   logic [slh_pkg::CNT_W-1:0] len_w;
   logic too_long;
   logic same;
   logic need_more;
   logic boundary_fail;

   always_comb begin
      entry = slh_pkg::kw_rom(idx);
      len_w = slh_pkg::CNT_W'(entry.len);
      too_long = fin && (len_w > la_cnt);
      // Compare the keyword against every buffered character it overlaps.
      same = 1'b1;
      for (int j = 0; j < slh_pkg::KW_MAX; j++) begin
         if ((slh_pkg::CNT_W'(j) < len_w) && (slh_pkg::CNT_W'(j) < la_cnt) &&
             (la_buf[j] != entry.txt[j])) begin
            same = 1'b0;
         end
      end
      need_more = (la_cnt < len_w + slh_pkg::CNT_W'(1)) && !fin;
      boundary_fail = (len_w < la_cnt) &&
                      slh_pkg::is_word(la_buf[slh_pkg::IDX_W'(entry.len)]);
      result.sty = entry.sty;
      result.len = entry.len;
      if (too_long || !same) begin
         result.verdict = slh_pkg::KW_SKIP;
      end else if (need_more) begin
         result.verdict = slh_pkg::KW_WAIT;
      end else if (boundary_fail) begin
         result.verdict = slh_pkg::KW_SKIP;
      end else begin
         result.verdict = slh_pkg::KW_MATCH;
      end
   end

endmodule
`default_nettype wire

/* design/syntax_highlight_lexer_core.sv */
// A character is taken only while the sequencer is idle. The sequencer then decides on the
// front of the lookahead buffer, writes the result for each character styled (stalling while
// the receiver holds back), and tries the keyword entries in turn (up to 54) when a letter
// starts a token. It goes back to idle, and so takes the next character, only once the buffer
// is empty or a decision has to wait for more characters.
// Reset (synchronous, active high) clears the context, mode, lookahead count and output.
`default_nettype none
module syntax_highlight_lexer_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [7:0] req_ch,
   input  wire logic req_first,
   input  wire logic [1:0] req_start_context,
   input  wire logic req_last,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [3:0] rsp_style,
   output logic rsp_out_last,
   output logic [1:0] rsp_end_context
);

   typedef enum logic [1:0] {ST_IDLE, ST_DECIDE, ST_KWSCAN, ST_EMIT} state_type;

   state_type state_ff, state_in;
   logic [1:0] ctx_ff, ctx_in;
   logic [1:0] mode_ff, mode_in;
   logic fin_ff, fin_in;
   logic last_ff, last_in;
   logic [slh_pkg::KW_IDX_W-1:0] kw_idx_ff, kw_idx_in;
   logic [3:0] emit_left_ff, emit_left_in;
   logic [3:0] emit_sty_ff, emit_sty_in;
   logic post_ctx_en_ff, post_ctx_en_in;
   logic [1:0] post_ctx_ff, post_ctx_in;
   logic post_mode_en_ff, post_mode_en_in;
   logic [1:0] post_mode_ff, post_mode_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [3:0] rsp_style_ff, rsp_style_in;
   logic rsp_last_ff, rsp_last_in;
   logic [1:0] rsp_ectx_ff, rsp_ectx_in;

   slh_pkg::la_ctrl_type la_ctrl;
   logic [slh_pkg::LOOKAHEAD_DEPTH-1:0][7:0] la_buf;
   logic [slh_pkg::CNT_W-1:0] la_cnt;
   logic [slh_pkg::CNT_W-1:0] base;
   slh_pkg::kw_result_type kw_res;

   // Decision for the front of the buffer.
   logic [3:0] d_n;
   logic [3:0] d_sty;
   logic d_wait;
   logic d_kw;
   logic d_pce;
   logic [1:0] d_pc;
   logic d_pme;
   logic [1:0] d_pm;
   logic lo_same;
   logic [7:0] c0;
   logic [7:0] c1;
   logic [1:0] ctx_after;
   logic final_res;

   slh_lookahead u_lookahead (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (la_ctrl),
      .buf_out(la_buf),
      .cnt_out(la_cnt)
   );

   slh_kw_unit u_kw_unit (
      .idx   (kw_idx_ff),
      .la_buf(la_buf),
      .la_cnt(la_cnt),
      .fin   (fin_ff),
      .result(kw_res)
   );

   always_comb begin
      c0 = la_buf[0];
      c1 = la_buf[1];
      d_n = 4'd0;
      d_sty = slh_pkg::STY_PLAIN;
      d_wait = 1'b0;
      d_kw = 1'b0;
      d_pce = 1'b0;
      d_pc = slh_pkg::CTX_PLAIN;
      d_pme = 1'b0;
      d_pm = slh_pkg::MODE_NONE;
      lo_same = ((la_cnt < 1) || (la_buf[0] == slh_pkg::CH_DASH)) &&
                ((la_cnt < 2) || (la_buf[1] == slh_pkg::CH_DASH)) &&
                ((la_cnt < 3) || (la_buf[2] == slh_pkg::CH_LBRACK)) &&
                ((la_cnt < 4) || (la_buf[3] == slh_pkg::CH_LBRACK));
      case (ctx_ff)
         slh_pkg::CTX_DSTRING: begin
            d_n = 4'd1;
            d_sty = slh_pkg::STY_DSTRING;
            d_pce = (c0 == slh_pkg::CH_DQUOTE);
         end
         slh_pkg::CTX_SSTRING: begin
            d_n = 4'd1;
            d_sty = slh_pkg::STY_SSTRING;
            d_pce = (c0 == slh_pkg::CH_SQUOTE);
         end
         slh_pkg::CTX_LONGCMT: begin
            d_sty = slh_pkg::STY_LONGCMT;
            d_n = 4'd1;
            if (c0 == slh_pkg::CH_RBRACK) begin
               if (la_cnt >= 2) begin
                  if (c1 == slh_pkg::CH_RBRACK) begin
                     d_n = 4'd2;
                     d_pce = 1'b1;
                  end
               end else if (!fin_ff) begin
                  d_n = 4'd0;
                  d_wait = 1'b1;
               end
            end
         end
         default: begin
            case (mode_ff)
               slh_pkg::MODE_NUMBER: begin
                  if (slh_pkg::is_numch(c0)) begin
                     d_n = 4'd1;
                     d_sty = slh_pkg::STY_NUMBER;
                  end else begin
                     d_pme = 1'b1;
                  end
               end
               slh_pkg::MODE_WORD: begin
                  if (slh_pkg::is_word(c0)) begin
                     d_n = 4'd1;
                  end else begin
                     d_pme = 1'b1;
                  end
               end
               slh_pkg::MODE_LINECMT: begin
                  if (c0 != slh_pkg::CH_NL) begin
                     d_n = 4'd1;
                     d_sty = slh_pkg::STY_COMMENT;
                  end else begin
                     d_pme = 1'b1;
                  end
               end
               default: begin
                  if (c0 == slh_pkg::CH_DQUOTE) begin
                     d_n = 4'd1;
                     d_sty = slh_pkg::STY_DSTRING;
                     d_pce = 1'b1;
                     d_pc = slh_pkg::CTX_DSTRING;
                  end else if (c0 == slh_pkg::CH_SQUOTE) begin
                     d_n = 4'd1;
                     d_sty = slh_pkg::STY_SSTRING;
                     d_pce = 1'b1;
                     d_pc = slh_pkg::CTX_SSTRING;
                  end else if (c0 == slh_pkg::CH_DASH) begin
                     if (lo_same && (la_cnt >= 4)) begin
                        d_n = 4'd4;
                        d_sty = slh_pkg::STY_LONGCMT;
                        d_pce = 1'b1;
                        d_pc = slh_pkg::CTX_LONGCMT;
                     end else if (lo_same && !fin_ff) begin
                        d_wait = 1'b1;
                     end else if ((la_cnt >= 2) && (c1 == slh_pkg::CH_DASH)) begin
                        d_n = 4'd2;
                        d_sty = slh_pkg::STY_COMMENT;
                        d_pme = 1'b1;
                        d_pm = slh_pkg::MODE_LINECMT;
                     end else begin
                        d_n = 4'd1;
                     end
                  end else if (slh_pkg::is_digit(c0)) begin
                     d_n = 4'd1;
                     d_sty = slh_pkg::STY_NUMBER;
                     d_pme = 1'b1;
                     d_pm = slh_pkg::MODE_NUMBER;
                  end else if (slh_pkg::is_alpha(c0)) begin
                     d_kw = 1'b1;
                  end else if ((c0 == slh_pkg::CH_LBRACE) || (c0 == slh_pkg::CH_RBRACE)) begin
                     d_n = 4'd1;
                     d_sty = slh_pkg::STY_BRACE;
                  end else begin
                     d_n = 4'd1;
                  end
               end
            endcase
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      ctx_in = ctx_ff;
      mode_in = mode_ff;
      fin_in = fin_ff;
      last_in = last_ff;
      kw_idx_in = kw_idx_ff;
      emit_left_in = emit_left_ff;
      emit_sty_in = emit_sty_ff;
      post_ctx_en_in = post_ctx_en_ff;
      post_ctx_in = post_ctx_ff;
      post_mode_en_in = post_mode_en_ff;
      post_mode_in = post_mode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_style_in = rsp_style_ff;
      rsp_last_in = rsp_last_ff;
      rsp_ectx_in = rsp_ectx_ff;
      la_ctrl = '0;
      la_ctrl.data = req_ch;
      base = req_first ? '0 : la_cnt;
      ctx_after = (post_ctx_en_ff && (emit_left_ff == 4'd1)) ? post_ctx_ff : ctx_ff;
      // The region's last result is the one that empties the buffer in a closing step.
      final_res = last_ff && (la_cnt == slh_pkg::CNT_W'(1));
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               la_ctrl.clear = req_first;
               la_ctrl.push = 1'b1;
               if (req_first) begin
                  ctx_in = req_start_context;
                  mode_in = slh_pkg::MODE_NONE;
               end
               fin_in = req_last || (base >= slh_pkg::CNT_W'(slh_pkg::LOOKAHEAD_DEPTH - 1));
               last_in = req_last;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (la_cnt == '0) begin
               if (last_ff) begin
                  mode_in = slh_pkg::MODE_NONE;
                  la_ctrl.clear = 1'b1;
               end
               state_in = ST_IDLE;
            end else if (d_wait) begin
               state_in = ST_IDLE;
            end else if (d_kw) begin
               kw_idx_in = '0;
               state_in = ST_KWSCAN;
            end else if (d_n != 4'd0) begin
               emit_left_in = d_n;
               emit_sty_in = d_sty;
               post_ctx_en_in = d_pce;
               post_ctx_in = d_pc;
               post_mode_en_in = d_pme;
               post_mode_in = d_pm;
               state_in = ST_EMIT;
            end else if (d_pme) begin
               mode_in = d_pm;
            end
         end
         ST_KWSCAN: begin
            case (kw_res.verdict)
               slh_pkg::KW_MATCH: begin
                  emit_left_in = kw_res.len;
                  emit_sty_in = kw_res.sty;
                  post_ctx_en_in = 1'b0;
                  post_mode_en_in = 1'b0;
                  state_in = ST_EMIT;
               end
               slh_pkg::KW_WAIT: begin
                  state_in = ST_IDLE;
               end
               default: begin
                  if (kw_idx_ff == slh_pkg::KW_IDX_W'(slh_pkg::NUM_KW - 1)) begin
                     emit_left_in = 4'd1;
                     emit_sty_in = slh_pkg::STY_PLAIN;
                     post_ctx_en_in = 1'b0;
                     post_mode_en_in = 1'b1;
                     post_mode_in = slh_pkg::MODE_WORD;
                     state_in = ST_EMIT;
                  end else begin
                     kw_idx_in = kw_idx_ff + slh_pkg::KW_IDX_W'(1);
                  end
               end
            endcase
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               la_ctrl.pop = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_style_in = emit_sty_ff;
               rsp_last_in = final_res;
               rsp_ectx_in = final_res ? ctx_after : slh_pkg::CTX_PLAIN;
               emit_left_in = emit_left_ff - 4'd1;
               if (emit_left_ff == 4'd1) begin
                  ctx_in = ctx_after;
                  if (post_mode_en_ff) begin
                     mode_in = post_mode_ff;
                  end
                  state_in = ST_DECIDE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ctx_ff <= slh_pkg::CTX_PLAIN;
         mode_ff <= slh_pkg::MODE_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ctx_ff <= ctx_in;
         mode_ff <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fin_ff <= fin_in;
      last_ff <= last_in;
      kw_idx_ff <= kw_idx_in;
      emit_left_ff <= emit_left_in;
      emit_sty_ff <= emit_sty_in;
      post_ctx_en_ff <= post_ctx_en_in;
      post_ctx_ff <= post_ctx_in;
      post_mode_en_ff <= post_mode_en_in;
      post_mode_ff <= post_mode_in;
      rsp_style_ff <= rsp_style_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ectx_ff <= rsp_ectx_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_style = rsp_style_ff;
   assign rsp_out_last = rsp_last_ff;
   assign rsp_end_context = rsp_ectx_ff;

   // A group of styles never asks for more characters than the buffer holds.
   a_emit_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> ((emit_left_ff != 4'd0) &&
                                 (slh_pkg::CNT_W'(emit_left_ff) <= la_cnt)))
      else $error("emit group exceeds lookahead");

   a_ectx_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_end_context != slh_pkg::CTX_PLAIN)) |-> rsp_out_last)
      else $error("end context without last mark");

   a_kw_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_KWSCAN) |-> (kw_idx_ff < slh_pkg::KW_IDX_W'(slh_pkg::NUM_KW)))
      else $error("keyword index out of range");

   a_first_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_first) |=> (la_cnt == slh_pkg::CNT_W'(1)))
      else $error("region start did not restart lookahead");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && rsp_last_in && !rsp_valid_ff) |=> (la_cnt == '0))
      else $error("last result left characters behind");

endmodule
`default_nettype wire

/* tb/sv/syntax_highlight_lexer_core_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module syntax_highlight_lexer_core_tb;
   import slh_pkg::*;

   typedef struct {
      logic [3:0] style;
      logic       out_last;
      logic [1:0] end_ctx;
   } style_rec_t;

   typedef struct {
      logic [7:0] ch;
      logic       first;
      logic [1:0] sc;
      logic       last;
      bit         typed;
      logic [3:0] sty;
      logic [1:0] ectx;
   } lex_row_t;

   logic clock, reset;
   logic req_valid, req_ready, req_first, req_last;
   logic [7:0] req_ch;
   logic [1:0] req_start_context;
   logic rsp_valid, rsp_ready, rsp_out_last;
   logic [3:0] rsp_style;
   logic [1:0] rsp_end_context;

   style_rec_t expected_styles[$];
   style_rec_t step_styles[$];
   int fail_count = 0;
   bit no_idle = 0;
   bit hold_rsp = 0;

   // Shadow lexer state.
   logic [1:0] ctx_q;
   logic [1:0] mode_q;
   logic [7:0] la_buf[LOOKAHEAD_DEPTH];
   int la_cnt;

   string kw_word[NUM_KW] = '{"nil", "true", "false", "_G", "_VERSION", "and", "break",
      "do", "else", "elseif", "end", "for", "function", "if", "in", "local", "nil", "not",
      "or", "repeat", "return", "then", "until", "while", "next", "pairs", "ipairs",
      "assert", "collectgarbage", "dofile", "error", "getfenv", "getmetatable", "setfenv",
      "setmetatable", "load", "loadfile", "loadstring", "pcall", "print", "rawequal",
      "rawget", "rawset", "select", "tonumber", "tostring", "type", "unpack", "xpcall",
      "table.insert", "table.remove", "con.printf", "con.ticker", "con.abort"};

   function automatic logic [3:0] kw_style(int i);
      if (i < 5) return STY_NUMBER;
      if (i < 24) return STY_KEYWORD;
      return STY_FUNCTION;
   endfunction

   function automatic bit digit_ch(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic bit alpha_ch(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction
   function automatic bit word_ch(logic [7:0] c);
      return alpha_ch(c) || digit_ch(c) || c == CH_UNDER;
   endfunction
   function automatic bit num_ch(logic [7:0] c);
      return digit_ch(c) || c == CH_DOT || c == "e" || c == "E";
   endfunction

   function automatic void put_styles(int n, logic [3:0] s);
      style_rec_t r;
      if (n > la_cnt) n = la_cnt;
      r.style = s;
      r.out_last = 0;
      r.end_ctx = CTX_PLAIN;
      for (int i = 0; i < n; i++) step_styles.push_back(r);
      for (int j = 0; j < la_cnt - n; j++) la_buf[j] = la_buf[j + n];
      la_cnt -= n;
   endfunction

   // -1 means more characters are needed, 0 no keyword, 1 keyword idx at the front.
   function automatic int match_keyword(bit fin, output int idx);
      int wl, m;
      bit same;
      idx = 0;
      for (int i = 0; i < NUM_KW; i++) begin
         wl = kw_word[i].len();
         if (fin && wl > la_cnt) continue;
         m = (wl < la_cnt) ? wl : la_cnt;
         same = 1;
         for (int j = 0; j < m; j++) begin
            if (la_buf[j] != kw_word[i][j]) same = 0;
         end
         if (!same) continue;
         if (la_cnt < wl + 1 && !fin) return -1;
         if (wl < la_cnt && word_ch(la_buf[wl])) continue;
         idx = i;
         return 1;
      end
      return 0;
   endfunction

   function automatic void lex_pending(bit fin);
      logic [7:0] c;
      int n, r, idx, m;
      bit same;
      while (la_cnt > 0) begin
         c = la_buf[0];
         n = la_cnt;
         if (ctx_q == CTX_DSTRING || ctx_q == CTX_SSTRING) begin
            put_styles(1, (ctx_q == CTX_DSTRING) ? STY_DSTRING : STY_SSTRING);
            if (c == ((ctx_q == CTX_DSTRING) ? CH_DQUOTE : CH_SQUOTE)) ctx_q = CTX_PLAIN;
         end else if (ctx_q == CTX_LONGCMT) begin
            if (c == CH_RBRACK && n >= 2 && la_buf[1] == CH_RBRACK) begin
               put_styles(2, STY_LONGCMT);
               ctx_q = CTX_PLAIN;
            end else if (c == CH_RBRACK && n < 2 && !fin) begin
               return;
            end else begin
               put_styles(1, STY_LONGCMT);
            end
         end else if (mode_q == MODE_NUMBER) begin
            if (num_ch(c)) put_styles(1, STY_NUMBER); else mode_q = MODE_NONE;
         end else if (mode_q == MODE_WORD) begin
            if (word_ch(c)) put_styles(1, STY_PLAIN); else mode_q = MODE_NONE;
         end else if (mode_q == MODE_LINECMT) begin
            if (c != CH_NL) put_styles(1, STY_COMMENT); else mode_q = MODE_NONE;
         end else if (c == CH_DQUOTE) begin
            put_styles(1, STY_DSTRING);
            ctx_q = CTX_DSTRING;
         end else if (c == CH_SQUOTE) begin
            put_styles(1, STY_SSTRING);
            ctx_q = CTX_SSTRING;
         end else if (c == CH_DASH) begin
            m = (n < 4) ? n : 4;
            same = 1;
            for (int j = 0; j < m; j++) begin
               if (la_buf[j] != ((j < 2) ? CH_DASH : CH_LBRACK)) same = 0;
            end
            if (same && m == 4) begin
               put_styles(4, STY_LONGCMT);
               ctx_q = CTX_LONGCMT;
            end else if (same && !fin) begin
               return;
            end else if (n >= 2 && la_buf[1] == CH_DASH) begin
               put_styles(2, STY_COMMENT);
               mode_q = MODE_LINECMT;
            end else begin
               put_styles(1, STY_PLAIN);
            end
         end else if (digit_ch(c)) begin
            put_styles(1, STY_NUMBER);
            mode_q = MODE_NUMBER;
         end else if (alpha_ch(c)) begin
            r = match_keyword(fin, idx);
            if (r < 0) return;
            if (r > 0) begin
               put_styles(kw_word[idx].len(), kw_style(idx));
            end else begin
               put_styles(1, STY_PLAIN);
               mode_q = MODE_WORD;
            end
         end else if (c == CH_LBRACE || c == CH_RBRACE) begin
            put_styles(1, STY_BRACE);
         end else begin
            put_styles(1, STY_PLAIN);
         end
      end
   endfunction

   function automatic void predict_styles(logic [7:0] c, logic f, logic [1:0] sc, logic l);
      step_styles.delete();
      if (f) begin
         la_cnt = 0;
         ctx_q = sc;
         mode_q = MODE_NONE;
      end
      if (la_cnt < LOOKAHEAD_DEPTH) begin
         la_buf[la_cnt] = c;
         la_cnt++;
      end
      lex_pending(l || la_cnt >= LOOKAHEAD_DEPTH);
      if (l) begin
         mode_q = MODE_NONE;
         la_cnt = 0;
         if (step_styles.size() > 0) begin
            step_styles[$].out_last = 1;
            step_styles[$].end_ctx = ctx_q;
         end
      end
   endfunction

   syntax_highlight_lexer_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_ch(req_ch),
      .req_first(req_first), .req_start_context(req_start_context), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_style(rsp_style),
      .rsp_out_last(rsp_out_last), .rsp_end_context(rsp_end_context)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Offers one character; returns at the falling edge after the transfer.
   task automatic send_char(logic [7:0] c, logic f, logic [1:0] sc, logic l,
                            bit typed = 0, logic [3:0] sty = STY_PLAIN,
                            logic [1:0] ectx = CTX_PLAIN);
      style_rec_t r;
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_ch = c;
      req_first = f;
      req_start_context = sc;
      req_last = l;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      predict_styles(c, f, sc, l);
      if (typed) begin
         r.style = sty;
         r.out_last = 1;
         r.end_ctx = ectx;
         expected_styles.push_back(r);
      end else begin
         foreach (step_styles[i]) expected_styles.push_back(step_styles[i]);
      end
      @(negedge clock);
   endtask

   logic [7:0] text_q[$];

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic add_token();
      case ($urandom_range(0, 9))
         0, 1, 2: add_text(kw_word[$urandom_range(0, NUM_KW - 1)]);
         3: add_text($urandom_range(0, 1) ? "ab9_x" : "Zq");
         4: add_text($urandom_range(0, 1) ? "3.1e5" : "42E");
         5: add_text($urandom_range(0, 1) ? "\"s]\"" : "'q'");
         6: add_text($urandom_range(0, 1) ? "--[[a]b]]" : "--c\n");
         7: add_text($urandom_range(0, 1) ? "{" : "}");
         8: text_q.push_back(8'($urandom_range(0, 255)));
         default: add_text($urandom_range(0, 1) ? " " : "\n(");
      endcase
   endtask

   task automatic send_region(output int count);
      int target;
      logic f;
      text_q.delete();
      target = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 24) : $urandom_range(1, 12);
      while (text_q.size() < target) add_token();
      f = $urandom_range(0, 9) != 0;
      for (int i = 0; i < text_q.size(); i++) begin
         send_char(text_q[i], (i == 0) ? f : ($urandom_range(0, 40) == 0),
                   2'($urandom), (i == text_q.size() - 1) && ($urandom_range(0, 7) != 0));
      end
      count = text_q.size();
   endtask

   lex_row_t lex_table[25] = '{
      '{CH_LBRACE, 1, CTX_PLAIN,   1, 1, STY_BRACE,   CTX_PLAIN},
      '{8'hff,     1, CTX_PLAIN,   1, 1, STY_PLAIN,   CTX_PLAIN},
      '{8'h00,     1, CTX_PLAIN,   1, 1, STY_PLAIN,   CTX_PLAIN},
      '{CH_DQUOTE, 1, CTX_PLAIN,   1, 1, STY_DSTRING, CTX_DSTRING},
      '{"x",       1, CTX_DSTRING, 1, 1, STY_DSTRING, CTX_DSTRING},
      '{CH_SQUOTE, 1, CTX_SSTRING, 1, 1, STY_SSTRING, CTX_PLAIN},
      '{"a",       1, CTX_LONGCMT, 1, 1, STY_LONGCMT, CTX_LONGCMT},
      '{CH_DASH,   1, CTX_PLAIN,   0, 0, STY_PLAIN,   CTX_PLAIN},
      '{CH_DASH,   0, CTX_PLAIN,   0, 0, STY_PLAIN,   CTX_PLAIN},
      '{CH_LBRACK, 0, CTX_PLAIN,   0, 0, STY_PLAIN,   CTX_PLAIN},
      '{CH_LBRACK, 0, CTX_PLAIN,   0, 0, STY_PLAIN,   CTX_PLAIN},
      '{CH_RBRACK, 0, CTX_PLAIN,   0, 0, STY_PLAIN,   CTX_PLAIN},
      '{CH_RBRACK, 0, CTX_PLAIN,   1, 0, STY_PLAIN,   CTX_PLAIN},
      '{"n",       1, CTX_PLAIN,   0, 0, STY_PLAIN,   CTX_PLAIN},
      '{"i",       0, CTX_PLAIN,   0, 0, STY_PLAIN,   CTX_PLAIN},
      '{"l",       0, CTX_PLAIN,   1, 0, STY_PLAIN,   CTX_PLAIN},
      '{"9",       1, CTX_PLAIN,   0, 0, STY_PLAIN,   CTX_PLAIN},
      '{CH_DOT,    0, CTX_PLAIN,   0, 0, STY_PLAIN,   CTX_PLAIN},
      '{"e",       0, CTX_PLAIN,   0, 0, STY_PLAIN,   CTX_PLAIN},
      '{CH_RBRACE, 0, CTX_PLAIN,   1, 0, STY_PLAIN,   CTX_PLAIN},
      '{CH_DASH,   1, CTX_PLAIN,   0, 0, STY_PLAIN,   CTX_PLAIN},
      '{CH_DASH,   0, CTX_PLAIN,   1, 0, STY_PLAIN,   CTX_PLAIN},
      '{"e",       1, CTX_PLAIN,   0, 0, STY_PLAIN,   CTX_PLAIN},
      '{"l",       0, CTX_PLAIN,   0, 0, STY_PLAIN,   CTX_PLAIN},
      '{"x",       1, CTX_PLAIN,   1, 0, STY_PLAIN,   CTX_PLAIN}
   };

   // Receiver: random back-pressure, plus one long hold-off on request.
   initial begin
      int n;
      rsp_ready = 0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready = 0;
            repeat (120) @(negedge clock);
            hold_rsp = 0;
         end
         n = no_idle ? 0 : $urandom_range(0, 3);
         if (n > 0) begin
            rsp_ready = 0;
            repeat (n) @(negedge clock);
         end
         rsp_ready = 1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      style_rec_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_styles.size() == 0) begin
            $error("unexpected style transfer: style %0d", rsp_style);
            fail_count++;
         end else begin
            e = expected_styles.pop_front();
            if (rsp_style !== e.style) begin
               $error("style: expected %0d, actual %0d", e.style, rsp_style);
               fail_count++;
            end
            if (rsp_out_last !== e.out_last) begin
               $error("out_last: expected %0d, actual %0d", e.out_last, rsp_out_last);
               fail_count++;
            end
            if (rsp_end_context !== e.end_ctx) begin
               $error("end_context: expected %0d, actual %0d", e.end_ctx, rsp_end_context);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int sent, cnt;
      reset = 1;
      req_valid = 0;
      req_ch = '0;
      req_first = 0;
      req_start_context = CTX_PLAIN;
      req_last = 0;
      ctx_q = CTX_PLAIN;
      mode_q = MODE_NONE;
      la_cnt = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (lex_table[i]) begin
         send_char(lex_table[i].ch, lex_table[i].first, lex_table[i].sc, lex_table[i].last,
                   lex_table[i].typed, lex_table[i].sty, lex_table[i].ectx);
      end

      // The sender waits here until every outstanding style has been transferred.
      req_valid = 0;
      wait (expected_styles.size() == 0);
      @(negedge clock);

      sent = 0;
      hold_rsp = 1;
      while (sent < 90) begin
         no_idle = (sent > 40 && sent < 65);
         send_region(cnt);
         sent += cnt;
      end
      no_idle = 0;
      req_valid = 0;

      wait (expected_styles.size() == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* sim.f */
design/slh_pkg.sv
design/slh_lookahead.sv
design/slh_kw_unit.sv
design/syntax_highlight_lexer_core.sv
tb/sv/syntax_highlight_lexer_core_tb.sv
